// ===== src/imufp_pkg.sv =====
// Shared types and constants for the IMU frame parser and converter.
// No dependencies; every other source file imports this package.
package imufp_pkg;

    // Frame layout.
    localparam logic [7:0] FRAME_HEADER = 8'h55;
    localparam logic [7:0] TYPE_FIRST   = 8'h50;
    localparam logic [7:0] TYPE_LAST    = 8'h59;
    localparam logic [3:0] POS_HEADER   = 4'd0;
    localparam logic [3:0] POS_TYPE     = 4'd1;
    localparam logic [3:0] POS_CHECKSUM = 4'd10;
    localparam int         PAYLOAD_LEN  = 8;
    localparam int         WORD_COUNT   = 4;

    // Frame kinds that get scaled.
    localparam logic [3:0] KIND_GYRO  = 4'd2;
    localparam logic [3:0] KIND_ANGLE = 4'd3;

    // Scale factors, signed so that the products stay signed.
    localparam logic signed [8:0] SCALE_UNIT  = 9'sd1;
    localparam logic signed [8:0] SCALE_GYRO  = 9'sd125;
    localparam logic signed [8:0] SCALE_ANGLE = 9'sd45;

    // Angle units are 1/8192 degree.
    localparam int                 ANGLE_FRAC_BITS = 13;
    localparam logic signed [9:0]  OFFSET_LIMIT    = 10'sd360;
    localparam logic signed [23:0] HALF_TURN       = 24'sd1474560;
    localparam logic signed [23:0] FULL_TURN       = 24'sd2949120;

    // Configuration port.
    localparam int         ADDR_W      = 3;
    localparam int         DATA_W      = 32;
    localparam logic       REG_COMPASS = 1'b0;

    // One checked frame as it crosses from the parser to the converter.
    typedef struct packed {
        logic [3:0]                   kind;
        logic [WORD_COUNT-1:0][15:0]  words;
    } t_frame;

endpackage

// ===== src/imufp_front.sv =====
// Frame parser: byte counter, running checksum and payload capture.
// Depends on imufp_pkg; hands checked frames to the queue.
module imufp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [7:0]         i_rx_byte,
    output logic               o_full,
    input  logic               i_q_full,
    output logic               o_frame_valid,
    output imufp_pkg::t_frame  o_frame
);
    import imufp_pkg::*;

    logic [3:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_type;
    logic [7:0] r_payload [PAYLOAD_LEN];
    logic       accept;
    logic       last_pos;
    logic       good;
    logic [2:0] pay_idx;

    // The checksum byte can only be taken when the queue has room.
    assign last_pos = (r_count >= POS_CHECKSUM);
    assign o_full   = last_pos && i_q_full;
    assign accept   = i_push && !o_full;
    assign pay_idx  = 3'(r_count - 4'd2);

    // A frame is good when the sum matches and the type is known.
    assign good = (r_sum == i_rx_byte) && (r_type >= TYPE_FIRST) && (r_type <= TYPE_LAST);
    assign o_frame_valid = accept && last_pos && good;

    // Assemble the frame from the stored bytes.
    always_comb begin
        o_frame.kind = 4'(r_type - TYPE_FIRST);
        for (int k = 0; k < WORD_COUNT; k++) begin
            o_frame.words[k] = {r_payload[2*k+1], r_payload[2*k]};
        end
    end

    // Next count and running sum.
    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        if (accept) begin
            if (r_count == POS_HEADER) begin
                if (i_rx_byte == FRAME_HEADER) begin
                    n_count = POS_TYPE;
                    n_sum   = i_rx_byte;
                end
            end else if (last_pos) begin
                n_count = POS_HEADER;
                n_sum   = 8'd0;
            end else begin
                n_count = r_count + 4'd1;
                n_sum   = r_sum + i_rx_byte;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= POS_HEADER;
            r_sum   <= 8'd0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

    // Frame contents are written before they are read, so no reset.
    always_ff @(posedge i_clk) begin
        if (accept && r_count == POS_TYPE) begin
            r_type <= i_rx_byte;
        end
        if (accept && r_count > POS_TYPE && !last_pos) begin
            r_payload[pay_idx] <= i_rx_byte;
        end
    end

endmodule

// ===== src/imufp_fifo.sv =====
// Short frame queue between the parser and the converter.
// Depends on imufp_pkg for the frame type.
module imufp_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  imufp_pkg::t_frame  i_wr_data,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_rd_en,
    output imufp_pkg::t_frame  o_rd_data
);
    import imufp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_frame            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_wr, do_rd;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign do_wr     = i_wr_en && !o_full;
    assign do_rd     = i_rd_en && o_valid;
    assign o_rd_data = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_rd) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_wr && !do_rd) begin
                r_count <= r_count + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ===== src/imufp_back.sv =====
// Converter: scales the first three words by kind, applies the compass offset to yaw
// and wraps it. Depends on imufp_pkg. Three stages, the last is the result.
module imufp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic signed [9:0]    i_offset,
    input  logic                 i_frame_valid,
    input  imufp_pkg::t_frame    i_frame,
    output logic                 o_frame_ready,
    output logic                 o_valid,
    input  logic                 i_pop,
    output logic [3:0]           o_packet_kind,
    output logic signed [23:0]   o_value_0,
    output logic signed [23:0]   o_value_1,
    output logic signed [23:0]   o_value_2,
    output logic signed [15:0]   o_value_3
);
    import imufp_pkg::*;

    // Stage A: scaled words.
    logic               r_a_valid;
    logic [3:0]         r_a_kind;
    logic signed [23:0] r_a_v [3];
    logic signed [15:0] r_a_w3;
    // Stage B: yaw with offset taken off.
    logic               r_b_valid;
    logic               r_b_comp;
    logic [3:0]         r_b_kind;
    logic signed [23:0] r_b_v [3];
    logic signed [15:0] r_b_w3;
    // Stage C: result register.
    logic               r_c_valid;

    logic               c_ready, b_ready, a_ready;
    logic               take_a, take_b, take_c;
    logic signed [8:0]  factor;
    logic signed [24:0] prod [3];
    logic signed [9:0]  off_sat;
    logic signed [23:0] off_units;
    logic signed [23:0] yaw_lo, yaw_wrapped;

    // Pipeline flow control.
    assign c_ready       = !r_c_valid || i_pop;
    assign b_ready       = !r_b_valid || c_ready;
    assign a_ready       = !r_a_valid || b_ready;
    assign take_a        = i_frame_valid && a_ready;
    assign take_b        = r_a_valid && b_ready;
    assign take_c        = r_b_valid && c_ready;
    assign o_frame_ready = a_ready;
    assign o_valid       = r_c_valid;

    // Scale factor by kind; one small multiplier for each of the first three words.
    always_comb begin
        case (i_frame.kind)
            KIND_GYRO:  factor = SCALE_GYRO;
            KIND_ANGLE: factor = SCALE_ANGLE;
            default:    factor = SCALE_UNIT;
        endcase
        for (int k = 0; k < 3; k++) begin
            prod[k] = signed'(i_frame.words[k]) * factor;
        end
    end

    // Offset clamped to one full turn, then in angle units.
    always_comb begin
        if (i_offset > OFFSET_LIMIT) begin
            off_sat = OFFSET_LIMIT;
        end else if (i_offset < -OFFSET_LIMIT) begin
            off_sat = -OFFSET_LIMIT;
        end else begin
            off_sat = i_offset;
        end
        off_units = 24'(off_sat) <<< ANGLE_FRAC_BITS;
    end

    // Wrap yaw once from below, then once from above.
    always_comb begin
        yaw_lo      = (r_b_v[2] < -HALF_TURN) ? r_b_v[2] + FULL_TURN : r_b_v[2];
        yaw_wrapped = (yaw_lo > HALF_TURN) ? yaw_lo - FULL_TURN : yaw_lo;
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_frame_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (take_a) begin
            r_a_kind <= i_frame.kind;
            for (int k = 0; k < 3; k++) begin
                r_a_v[k] <= prod[k][23:0];
            end
            r_a_w3 <= signed'(i_frame.words[3]);
        end
        if (take_b) begin
            r_b_kind <= r_a_kind;
            r_b_comp <= (r_a_kind == KIND_ANGLE) && (i_offset != 10'sd0);
            r_b_v[0] <= r_a_v[0];
            r_b_v[1] <= r_a_v[1];
            r_b_v[2] <= ((r_a_kind == KIND_ANGLE) && (i_offset != 10'sd0))
                        ? r_a_v[2] - off_units : r_a_v[2];
            r_b_w3   <= r_a_w3;
        end
        if (take_c) begin
            o_packet_kind <= r_b_kind;
            o_value_0     <= r_b_v[0];
            o_value_1     <= r_b_v[1];
            o_value_2     <= r_b_comp ? yaw_wrapped : r_b_v[2];
            o_value_3     <= r_b_w3;
        end
    end

endmodule

// ===== src/imu_frame_parse_convert.sv =====
// IMU frame parser and converter, top level: parser, frame queue,
// converter and the compass offset register. Depends on imufp_pkg.
// Throughput: one byte per cycle while full is low; frames overlap in the pipeline.
// Path: the edge that accepts a checksum byte writes the queue, then the scale,
// offset and result stages follow in order; a held result stalls them.
// Reset: synchronous, active low; clears framing, queue, valid bits and the compass offset.
module imu_frame_parse_convert #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [7:0]                     i_rx_byte,
    output logic                           empty,
    input  logic                           pop,
    output logic [3:0]                     o_packet_kind,
    output logic signed [23:0]             o_value_0,
    output logic signed [23:0]             o_value_1,
    output logic signed [23:0]             o_value_2,
    output logic signed [15:0]             o_value_3,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [imufp_pkg::ADDR_W-1:0]   paddr,
    input  logic [imufp_pkg::DATA_W-1:0]   pwdata,
    output logic [imufp_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import imufp_pkg::*;

    logic signed [9:0] r_compass;
    logic              reg_sel;
    logic              front_valid;
    t_frame            front_frame;
    t_frame            q_frame;
    logic              q_full, q_valid, back_ready;
    logic              out_valid;

    // Configuration register.
    assign pready  = 1'b1;
    assign reg_sel = (paddr[ADDR_W-1:2] == REG_COMPASS);
    assign prdata  = reg_sel ? DATA_W'(r_compass) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_compass <= 10'sd0;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            r_compass <= signed'(pwdata[9:0]);
        end
    end

    // Parser.
    imufp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_rx_byte     (i_rx_byte),
        .o_full        (full),
        .i_q_full      (q_full),
        .o_frame_valid (front_valid),
        .o_frame       (front_frame)
    );

    // Queue of checked frames.
    imufp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (front_valid),
        .i_wr_data (front_frame),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .i_rd_en   (back_ready),
        .o_rd_data (q_frame)
    );

    // Converter.
    imufp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_offset      (r_compass),
        .i_frame_valid (q_valid),
        .i_frame       (q_frame),
        .o_frame_ready (back_ready),
        .o_valid       (out_valid),
        .i_pop         (pop),
        .o_packet_kind (o_packet_kind),
        .o_value_0     (o_value_0),
        .o_value_1     (o_value_1),
        .o_value_2     (o_value_2),
        .o_value_3     (o_value_3)
    );

    assign empty = !out_valid;

endmodule

// ===== src/imufp_checker.sv =====
// Port-level checks for the IMU frame parser and converter.
// Depends on imufp_pkg; bound to the top level below.
module imufp_port_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           empty,
    input  logic                           pop,
    input  logic [3:0]                     o_packet_kind,
    input  logic signed [23:0]             o_value_0,
    input  logic signed [23:0]             o_value_1,
    input  logic signed [23:0]             o_value_2,
    input  logic signed [15:0]             o_value_3,
    input  logic                           pready
);
    import imufp_pkg::*;

    // Reset leaves no result waiting.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending right after reset");

    // Only known frame kinds come out.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_packet_kind <= 4'd9))
        else $error("unknown frame kind on the result");

    // Yaw of an angle frame always lands within a half turn.
    a_yaw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_packet_kind == KIND_ANGLE) |->
        (o_value_2 >= -HALF_TURN && o_value_2 <= HALF_TURN))
        else $error("yaw outside a half turn");

    // A result that is not taken stays as it is.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_packet_kind) && $stable(o_value_0)
        && $stable(o_value_1) && $stable(o_value_2) && $stable(o_value_3)))
        else $error("waiting result changed or vanished");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

endmodule

bind imu_frame_parse_convert imufp_port_checker u_checker (.*);

// ===== tb/imufp_checker.sv =====
// Checker for the IMU frame parser: watches the byte, result and register ports,
// predicts each result and compares it field by field. Depends on imufp_pkg.
`timescale 1ns / 100ps

module imufp_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    input  logic                               full,
    input  logic [7:0]                         i_rx_byte,
    input  logic                               empty,
    input  logic                               pop,
    input  logic [3:0]                         i_packet_kind,
    input  logic signed [23:0]                 i_value_0,
    input  logic signed [23:0]                 i_value_1,
    input  logic signed [23:0]                 i_value_2,
    input  logic signed [15:0]                 i_value_3,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [imufp_pkg::ADDR_W-1:0]       paddr,
    input  logic [imufp_pkg::DATA_W-1:0]       pwdata,
    input  logic                               pready,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_checked
);
    import imufp_pkg::*;

    // Fixed-point units of the converted values.
    localparam int GYRO_GAIN       = 125;
    localparam int ANGLE_GAIN      = 45;
    localparam int UNITS_PER_DEG   = 8192;
    localparam int HALF_TURN_UNITS = 180 * UNITS_PER_DEG;
    localparam int FULL_TURN_UNITS = 360 * UNITS_PER_DEG;
    localparam int OFFSET_CLAMP    = 360;
    localparam int COMPASS_ADDR    = 4 * int'(REG_COMPASS);

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [23:0] v0;
        logic signed [23:0] v1;
        logic signed [23:0] v2;
        logic signed [15:0] v3;
    } t_imu_result;

    // Shadow of the block's framing state and offset register.
    logic [3:0]        frame_pos;
    logic [7:0]        frame_sum;
    logic [7:0]        frame_type;
    logic [7:0]        payload [PAYLOAD_LEN];
    logic signed [9:0] compass_deg;

    t_imu_result converted_frames [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        frame_pos    = POS_HEADER;
        frame_sum    = 8'd0;
        compass_deg  = '0;
    end

    // Advance the frame parser by one byte; a complete good frame of a
    // known kind queues its converted result.
    task automatic take_byte(input logic [7:0] b);
        t_imu_result r;
        int          word [WORD_COUNT];
        int          off;
        int          k;
        if (frame_pos == POS_HEADER) begin
            if (b == FRAME_HEADER) begin
                frame_sum = b;
                frame_pos = POS_TYPE;
            end
        end else if (frame_pos == POS_TYPE) begin
            frame_type = b;
            frame_sum  = frame_sum + b;
            frame_pos  = frame_pos + 4'd1;
        end else if (frame_pos < POS_CHECKSUM) begin
            payload[int'(frame_pos) - 2] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end else begin
            frame_pos = POS_HEADER;
            if (frame_sum == b && frame_type >= TYPE_FIRST && frame_type <= TYPE_LAST) begin
                r.kind = 4'(frame_type - TYPE_FIRST);
                for (k = 0; k < WORD_COUNT; k++)
                    word[k] = int'($signed({payload[2*k+1], payload[2*k]}));
                for (k = 0; k < 3; k++) begin
                    if (r.kind == KIND_GYRO)
                        word[k] = word[k] * GYRO_GAIN;
                    else if (r.kind == KIND_ANGLE)
                        word[k] = word[k] * ANGLE_GAIN;
                end
                // Yaw: take off the saturated compass offset, then wrap once.
                if (r.kind == KIND_ANGLE && compass_deg != 0) begin
                    off = int'(compass_deg);
                    if (off > OFFSET_CLAMP)
                        off = OFFSET_CLAMP;
                    if (off < -OFFSET_CLAMP)
                        off = -OFFSET_CLAMP;
                    word[2] = word[2] - off * UNITS_PER_DEG;
                    if (word[2] < -HALF_TURN_UNITS)
                        word[2] = word[2] + FULL_TURN_UNITS;
                    if (word[2] > HALF_TURN_UNITS)
                        word[2] = word[2] - FULL_TURN_UNITS;
                end
                r.v0 = word[0][23:0];
                r.v1 = word[1][23:0];
                r.v2 = word[2][23:0];
                r.v3 = word[3][15:0];
                converted_frames.push_back(r);
            end
            frame_sum = 8'd0;
        end
    endtask

    function automatic bit field_ok(input string name, input int want, input int got);
        if (want != got)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        return want == got;
    endfunction

    // Compare the result beat on the ports with the oldest prediction.
    task automatic check_result();
        t_imu_result r;
        bit          ok;
        if (converted_frames.size() == 0) begin
            $display("%0t ns: unexpected result, kind %0d values %0d %0d %0d %0d", $time,
                     i_packet_kind, i_value_0, i_value_1, i_value_2, i_value_3);
            o_fail_count++;
        end else begin
            r  = converted_frames.pop_front();
            ok = field_ok("packet_kind", int'(r.kind), int'(i_packet_kind))
               & field_ok("value_0", int'(r.v0), int'(i_value_0))
               & field_ok("value_1", int'(r.v1), int'(i_value_1))
               & field_ok("value_2", int'(r.v2), int'(i_value_2))
               & field_ok("value_3", int'(r.v3), int'(i_value_3));
            if (!ok)
                o_fail_count++;
            o_checked++;
        end
    endtask

    // Sample at the falling edge: every beat seen here is taken at the next rising edge.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            frame_pos   = POS_HEADER;
            frame_sum   = 8'd0;
            compass_deg = '0;
            converted_frames.delete();
        end else begin
            if (psel && penable && pwrite && pready && int'(paddr) == COMPASS_ADDR)
                compass_deg = pwdata[9:0];
            if (push && !full)
                take_byte(i_rx_byte);
            if (pop && !empty)
                check_result();
        end
        o_pending = converted_frames.size();
    end

endmodule

// ===== tb/tb.sv =====
// Top of the IMU frame parser testbench: clock, reset, byte and register stimulus,
// result back-pressure and the verdict. Depends on imufp_pkg and imufp_checker.
`timescale 1ns / 100ps

module tb;
    import imufp_pkg::*;

    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_BYTES  = 75;
    localparam int PHASES       = 6;
    localparam int COMPASS_ADDR = 4 * int'(REG_COMPASS);

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                push      = 1'b0;
    logic                full;
    logic [7:0]          i_rx_byte = 8'd0;
    logic                empty;
    logic                pop       = 1'b0;
    logic [3:0]          o_packet_kind;
    logic signed [23:0]  o_value_0;
    logic signed [23:0]  o_value_1;
    logic signed [23:0]  o_value_2;
    logic signed [15:0]  o_value_3;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ADDR_W-1:0]   paddr     = '0;
    logic [DATA_W-1:0]   pwdata    = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int fail_count;
    int pending;
    int checked;
    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_requests  = 0;
    int bytes_sent     = 0;
    int frames_sent    = 0;
    int cycle_count    = 0;

    imu_frame_parse_convert i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_packet_kind (o_packet_kind),
        .o_value_0     (o_value_0),
        .o_value_1     (o_value_1),
        .o_value_2     (o_value_2),
        .o_value_3     (o_value_3),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    imufp_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .i_packet_kind (o_packet_kind),
        .i_value_0     (o_value_0),
        .i_value_1     (o_value_1),
        .i_value_2     (o_value_2),
        .i_value_3     (o_value_3),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Run limit of %0d cycles reached with %0d results pending.",
                         CYCLE_LIMIT, pending);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin
        int holds_started;
        int hold_left;
        holds_started = 0;
        hold_left     = 0;
        forever begin
            @(posedge i_clk);
            if (holds_started != hold_requests) begin
                holds_started = hold_requests;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Offer one byte after a random gap and hold it until the beat is taken.
    task automatic put_byte(input logic [7:0] b);
        bit was_full;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push      <= 1'b1;
        i_rx_byte <= b;
        do begin
            @(negedge i_clk);
            was_full = full;
            @(posedge i_clk);
        end while (was_full);
        bytes_sent++;
    endtask

    // Send the first length bytes of a frame; corrupt spoils the checksum.
    task automatic send_frame(input logic [7:0] type_code, input logic [3:0][15:0] w,
                              input bit corrupt, input int length);
        logic [7:0] frame [11];
        logic [7:0] sum;
        int         k;
        frame[0] = FRAME_HEADER;
        frame[1] = type_code;
        for (k = 0; k < WORD_COUNT; k++) begin
            frame[2 + 2*k] = w[k][7:0];
            frame[3 + 2*k] = w[k][15:8];
        end
        sum = 8'd0;
        for (k = 0; k < 10; k++)
            sum = sum + frame[k];
        frame[10] = corrupt ? (sum ^ 8'($urandom_range(255, 1))) : sum;
        for (k = 0; k < length; k++)
            put_byte(frame[k]);
        frames_sent++;
    endtask

    // Random word, with the sign and range corners picked often.
    function automatic logic [15:0] pick_word();
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h0000;
                default: return 16'hFFFF;
            endcase
        end
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_type();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return TYPE_FIRST + 8'(KIND_ANGLE);
        if (r < 85)
            return TYPE_FIRST + 8'($urandom_range(9));
        return 8'($urandom);
    endfunction

    // Mostly well-formed frames, some with bad sums, plus stray bytes and cut frames.
    task automatic send_random_traffic(input int stop_at);
        logic [3:0][15:0] w;
        int               r;
        int               k;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(99);
            for (k = 0; k < WORD_COUNT; k++)
                w[k] = pick_word();
            if (r < 8)
                put_byte(8'($urandom));
            else if (r < 14)
                send_frame(pick_type(), w, 1'b0, $urandom_range(10, 1));
            else
                send_frame(pick_type(), w, $urandom_range(99) < 12, 11);
        end
    endtask

    // Stop sending and wait until every predicted result has been taken.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input int addr, input logic [DATA_W-1:0] data);
        bit ready_seen;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr[ADDR_W-1:0];
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            ready_seen = pready;
            @(posedge i_clk);
        end while (!ready_seen);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
    endtask

    // Main stimulus.
    initial begin
        logic [3:0][15:0] w;
        int               offsets [PHASES];
        int               offset;
        int               phase;
        int               k;
        offsets = '{360, -360, 511, -512, 0, 0};
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idle(22, 56);

        // Directed: stray bytes where a header belongs.
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(FRAME_HEADER - 8'd1);

        // Every kind, with the word extremes in both arrangements.
        for (k = 0; k <= int'(TYPE_LAST - TYPE_FIRST); k++) begin
            if (k % 2 == 0)
                w = {16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF};
            else
                w = {16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000};
            send_frame(TYPE_FIRST + 8'(k), w, 1'b0, 11);
        end

        // Bad checksum, then good checksums on types just outside the valid range.
        w = {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0};
        send_frame(TYPE_FIRST + 8'd1, w, 1'b1, 11);
        send_frame(TYPE_LAST + 8'd1, w, 1'b0, 11);
        send_frame(TYPE_FIRST - 8'd1, w, 1'b0, 11);

        // One phase per compass offset; the extremes and out-of-range values first.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase / 2)
                0: set_idle(22, 56);
                1: set_idle(56, 22);
                default: set_idle(0, 0);
            endcase
            offset = (phase == 4) ? $urandom_range(720) - 360 : offsets[phase];
            wait_drained();
            write_reg(COMPASS_ADDR, DATA_W'(offset));

            // Yaw at its extremes and at zero, so the wrap goes both ways.
            for (k = 0; k < 3; k++) begin
                w[0] = pick_word();
                w[1] = pick_word();
                w[3] = pick_word();
                w[2] = (k == 0) ? 16'h8000 : (k == 1) ? 16'h0000 : 16'h7FFF;
                send_frame(TYPE_FIRST + 8'(KIND_ANGLE), w, 1'b0, 11);
            end

            // Hold off the result side while frames keep arriving, to fill the block.
            if (phase == 4) begin
                hold_requests++;
                for (k = 0; k < 10; k++) begin
                    w = {pick_word(), pick_word(), pick_word(), pick_word()};
                    send_frame(TYPE_FIRST + 8'($urandom_range(9)), w, 1'b0, 11);
                end
            end

            send_random_traffic(bytes_sent + PHASE_BYTES);
        end

        wait_drained();
        $display("Sent %0d bytes in %0d frames and checked %0d results,", bytes_sent,
                 frames_sent, checked);
        $display("over %0d offset settings, three idle mixes and a full-queue stall.",
                 PHASES);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
